FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk while rst_n is high.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Check that post holds in the cycle after pre, while rst_n is high.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

FILE: design/ctk_pkg.sv
// ----------------------------------------------------------------------------
// ctk_pkg
// Shared types and constants of the CSV field tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctk_pkg;

	localparam int BYTE_W    = 8;
	localparam int COUNT_W   = 8;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [COUNT_W-1:0] FIELD_CAP = 8'd255;

	localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd44;
	localparam logic [BYTE_W-1:0] QUOTE_RESET = 8'd34;

	localparam logic [CFG_IDX_W-1:0] CFG_DELIM = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUOTE = 2'd1;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TRAILING = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd2;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              last;
		logic              is_quote;
		logic              is_delim;
	} tok_item_t;

endpackage

FILE: design/ctk_fifo.sv
// ----------------------------------------------------------------------------
// ctk_fifo
// Short queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctk_fifo import ctk_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tok_item_t push_item,
	output logic      full,
	input  logic      pop,
	output tok_item_t pop_item,
	output logic      empty
);

	tok_item_t          slots_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full     = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/ctk_front.sv
// ----------------------------------------------------------------------------
// ctk_front
// Holds the delimiter and quote registers and classifies each input byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctk_front import ctk_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [BYTE_W-1:0]    in_byte,
	input  logic                 last_of_record,
	output logic                 push,
	output tok_item_t            push_item,
	input  logic                 full
);

	logic [BYTE_W-1:0] delim_q;
	logic [BYTE_W-1:0] quote_q;
	logic              match_quote;

	assign cfg_ready = 1'b1;
	assign in_ready  = !full;
	assign push      = in_valid && !full;

	// Quote wins when both registers hold the same byte.
	assign match_quote        = (in_byte == quote_q);
	assign push_item.value    = in_byte;
	assign push_item.last     = last_of_record;
	assign push_item.is_quote = match_quote;
	assign push_item.is_delim = (in_byte == delim_q) && !match_quote;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DELIM_RESET;
			quote_q <= QUOTE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DELIM: delim_q <= cfg_data;
				CFG_QUOTE: quote_q <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

FILE: design/ctk_back.sv
// ----------------------------------------------------------------------------
// ctk_back
// Tracks quoting and field counts and registers one result per byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctk_back import ctk_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  tok_item_t           pop_item,
	input  logic                empty,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                data_valid,
	output logic [BYTE_W-1:0]   data_byte,
	output logic                field_end,
	output logic                record_end,
	output logic [STATUS_W-1:0] status,
	output logic [COUNT_W-1:0]  fields_in_record
);

	logic                quote_open_q;
	logic                prev_quote_q;
	logic [COUNT_W-1:0]  field_cnt_q;
	logic [COUNT_W-1:0]  expected_q;
	logic                expected_known_q;

	logic                qo_n;
	logic                pq_n;
	logic [COUNT_W-1:0]  cnt_mid;
	logic [COUNT_W-1:0]  cnt_n;
	logic                dv;
	logic                fe;
	logic                trailing;
	logic [STATUS_W-1:0] st;

	assign pop = !empty && (!out_valid || out_ready);

	always_comb begin
		qo_n     = quote_open_q;
		pq_n     = 1'b0;
		cnt_mid  = field_cnt_q;
		dv       = 1'b0;
		fe       = 1'b0;
		trailing = 1'b0;
		st       = ST_OK;
		if (pop_item.is_quote) begin
			qo_n = !quote_open_q;
			dv   = !quote_open_q && prev_quote_q;
			pq_n = 1'b1;
		end else if (pop_item.is_delim) begin
			if (quote_open_q) begin
				dv = 1'b1;
			end else begin
				fe       = 1'b1;
				cnt_mid  = (field_cnt_q != FIELD_CAP) ? field_cnt_q + 1'b1 : field_cnt_q;
				trailing = pop_item.last;
			end
		end else begin
			dv = 1'b1;
		end
		cnt_n = cnt_mid;
		if (pop_item.last) begin
			fe    = 1'b1;
			cnt_n = (cnt_mid != FIELD_CAP) ? cnt_mid + 1'b1 : cnt_mid;
			if (trailing) begin
				st = ST_TRAILING;
			end else if (expected_known_q && (cnt_n != expected_q)) begin
				st = ST_MISMATCH;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_valid       <= dv;
			data_byte        <= dv ? pop_item.value : '0;
			field_end        <= fe;
			record_end       <= pop_item.last;
			status           <= st;
			fields_in_record <= cnt_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid        <= 1'b0;
			quote_open_q     <= 1'b0;
			prev_quote_q     <= 1'b0;
			field_cnt_q      <= '0;
			expected_q       <= '0;
			expected_known_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (pop) begin
				if (pop_item.last) begin
					quote_open_q <= 1'b0;
					prev_quote_q <= 1'b0;
					field_cnt_q  <= '0;
					if (!trailing && !expected_known_q) begin
						expected_q       <= cnt_n;
						expected_known_q <= 1'b1;
					end
				end else begin
					quote_open_q <= qo_n;
					prev_quote_q <= pq_n;
					field_cnt_q  <= cnt_n;
				end
			end
		end
	end

endmodule

FILE: design/csv_field_tokenizer.sv
// A byte accepted by the front is loaded into the queue, popped into the output
// register once that register is free or being read, and offered from then on.
// Throughput: one byte per cycle; the back end retires one beat per cycle unless stalled.
// A four-entry queue lets the front accept while the output register is stalled.
// Reset (arst_n low) clears the queue, quoting and count state, and loads the
// delimiter and quote registers with comma and double quote.
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// Streaming CSV field tokenizer: quote removal, field and record delimiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csv_field_tokenizer import ctk_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [BYTE_W-1:0]    in_byte,
	input  logic                 last_of_record,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 data_valid,
	output logic [BYTE_W-1:0]    data_byte,
	output logic                 field_end,
	output logic                 record_end,
	output logic [STATUS_W-1:0]  status,
	output logic [COUNT_W-1:0]   fields_in_record
);

	logic      push;
	tok_item_t push_item;
	logic      full;
	logic      pop;
	tok_item_t pop_item;
	logic      empty;

	ctk_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_byte        (in_byte),
		.last_of_record (last_of_record),
		.push           (push),
		.push_item      (push_item),
		.full           (full)
	);

	ctk_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (empty)
	);

	ctk_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.pop_item         (pop_item),
		.empty            (empty),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.data_valid       (data_valid),
		.data_byte        (data_byte),
		.field_end        (field_end),
		.record_end       (record_end),
		.status           (status),
		.fields_in_record (fields_in_record)
	);

endmodule

FILE: design/ctk_checker.sv
// ----------------------------------------------------------------------------
// ctk_checker
// Port-level checks of the CSV field tokenizer result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ctk_checker import ctk_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic                 data_valid,
	input logic [BYTE_W-1:0]    data_byte,
	input logic                 field_end,
	input logic                 record_end,
	input logic [STATUS_W-1:0]  status,
	input logic [COUNT_W-1:0]   fields_in_record
);

	logic out_stall;

	assign out_stall = out_valid && !out_ready;

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, out_valid && $stable(data_byte) && $stable(status))
	`ASSERT_NEXT(a_count_hold, clk, arst_n, out_stall, $stable(fields_in_record))
	`ASSERT_CLK(a_idle_byte_zero, clk, arst_n, out_valid && !data_valid |-> data_byte == '0)
	`ASSERT_CLK(a_status_at_end, clk, arst_n, out_valid && (status != ST_OK) |-> record_end)
	`ASSERT_CLK(a_end_closes_field, clk, arst_n, out_valid && record_end |-> field_end && (fields_in_record != '0))

endmodule

bind csv_field_tokenizer ctk_checker u_ctk_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the CSV field tokenizer. Records are fed one byte per beat
// under several delimiter and quote settings, including the byte extremes and
// a shared quote/delimiter byte. Each phase opens with register writes while
// the block is idle. A scoreboard predicts every result beat from its own copy
// of the quoting and field-count state and compares each returned beat, field
// by field. The sender pauses in random bursts and the receiver stalls on a
// changing pattern.
// ----------------------------------------------------------------------------

module tb_top;
	import ctk_pkg::*;

	localparam int N_SETTINGS      = 6;
	localparam int BYTES_PER_PHASE = 42;
	localparam int REPORT_LIMIT    = 10;

	typedef struct packed {
		logic                data_valid;
		logic [BYTE_W-1:0]   data_byte;
		logic                field_end;
		logic                record_end;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  fields_in_record;
	} token_beat_t;

	class field_scoreboard;
		logic [BYTE_W-1:0]  delim_char;
		logic [BYTE_W-1:0]  quote_char;
		logic               quote_open;
		logic               prev_quote;
		logic [COUNT_W-1:0] closed_fields;
		logic [COUNT_W-1:0] expected_fields;
		logic               expected_known;
		token_beat_t        pending_beats[$];
		int                 bad_beats;
		int                 bytes_seen;
		int                 records_seen;
		int                 doubled_quotes;
		int                 status_seen[4];

		function new();
			delim_char      = DELIM_RESET;
			quote_char      = QUOTE_RESET;
			quote_open      = 1'b0;
			prev_quote      = 1'b0;
			closed_fields   = '0;
			expected_fields = '0;
			expected_known  = 1'b0;
			bad_beats       = 0;
			bytes_seen      = 0;
			records_seen    = 0;
			doubled_quotes  = 0;
			status_seen     = '{0, 0, 0, 0};
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
			if (idx == CFG_DELIM)
				delim_char = val;
			else if (idx == CFG_QUOTE)
				quote_char = val;
		endfunction

		function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] n);
			return (n < FIELD_CAP) ? n + 1'b1 : FIELD_CAP;
		endfunction

		function void note_byte(logic [BYTE_W-1:0] b, logic last);
			token_beat_t e;
			logic        trailing;
			e = '0;
			trailing = 1'b0;
			if (b == quote_char) begin
				quote_open = !quote_open;
				if (quote_open && prev_quote) begin
					e.data_valid = 1'b1;
					e.data_byte  = b;
					doubled_quotes++;
				end
				prev_quote = 1'b1;
			end else if (b == delim_char) begin
				prev_quote = 1'b0;
				if (quote_open) begin
					e.data_valid = 1'b1;
					e.data_byte  = b;
				end else begin
					e.field_end   = 1'b1;
					closed_fields = bump(closed_fields);
					trailing      = last;
				end
			end else begin
				prev_quote   = 1'b0;
				e.data_valid = 1'b1;
				e.data_byte  = b;
			end
			e.status = ST_OK;
			if (last) begin
				e.field_end   = 1'b1;
				closed_fields = bump(closed_fields);
				if (trailing) begin
					e.status = ST_TRAILING;
				end else if (!expected_known) begin
					expected_fields = closed_fields;
					expected_known  = 1'b1;
				end else if (closed_fields != expected_fields) begin
					e.status = ST_MISMATCH;
				end
			end
			e.record_end       = last;
			e.fields_in_record = closed_fields;
			if (last) begin
				quote_open    = 1'b0;
				prev_quote    = 1'b0;
				closed_fields = '0;
				records_seen++;
				status_seen[e.status]++;
			end
			bytes_seen++;
			pending_beats.insert(pending_beats.size(), e);
		endfunction

		function void check_beat(token_beat_t got);
			token_beat_t e;
			if (pending_beats.size() == 0) begin
				bad_beats++;
				if (bad_beats <= REPORT_LIMIT)
					$display("%0t: result beat with nothing expected: %p", $realtime, got);
				return;
			end
			e = pending_beats.pop_front();
			if (got.data_valid !== e.data_valid || got.data_byte !== e.data_byte ||
					got.field_end !== e.field_end || got.record_end !== e.record_end ||
					got.status !== e.status || got.fields_in_record !== e.fields_in_record) begin
				bad_beats++;
				if (bad_beats <= REPORT_LIMIT) begin
					$display("%0t: beat mismatch", $realtime);
					$display("  expected dv=%0b byte=%02h fe=%0b re=%0b st=%0d fields=%0d",
						e.data_valid, e.data_byte, e.field_end, e.record_end,
						e.status, e.fields_in_record);
					$display("  actual   dv=%0b byte=%02h fe=%0b re=%0b st=%0d fields=%0d",
						got.data_valid, got.data_byte, got.field_end, got.record_end,
						got.status, got.fields_in_record);
				end
			end
		endfunction

		function int pending();
			return pending_beats.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_DELIM;
	logic [BYTE_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [BYTE_W-1:0]    in_byte = '0;
	logic                 last_of_record = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 data_valid;
	logic [BYTE_W-1:0]    data_byte;
	logic                 field_end;
	logic                 record_end;
	logic [STATUS_W-1:0]  status;
	logic [COUNT_W-1:0]   fields_in_record;

	field_scoreboard   sb;
	logic [BYTE_W-1:0] rec_bytes[$];
	logic [BYTE_W-1:0] cur_delim = DELIM_RESET;
	logic [BYTE_W-1:0] cur_quote = QUOTE_RESET;
	logic [BYTE_W-1:0] delim_set[N_SETTINGS] = '{8'd44, 8'd34, 8'd0, 8'd255, 8'd9, 8'd44};
	logic [BYTE_W-1:0] quote_set[N_SETTINGS] = '{8'd34, 8'd34, 8'd255, 8'd0, 8'd39, 8'd34};
	int                burst_left = 0;
	int                rx_mode = 0;
	int                rx_window = 0;
	int                rx_tick = 0;

	csv_field_tokenizer DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.in_byte          (in_byte),
		.last_of_record   (last_of_record),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.data_valid       (data_valid),
		.data_byte        (data_byte),
		.field_end        (field_end),
		.record_end       (record_end),
		.status           (status),
		.fields_in_record (fields_in_record)
	);

	always #10 clk = ~clk;

	// receiver: switch stall pattern every window
	always @(posedge clk) begin
		if (rx_window == 0) begin
			rx_mode   = $urandom_range(0, 3);
			rx_window = $urandom_range(20, 80);
		end
		rx_window--;
		rx_tick++;
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= ((rx_tick % 5) < 2);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_beat('{data_valid, data_byte, field_end, record_end, status,
				fields_in_record});
	end

	function automatic void add_byte(logic [BYTE_W-1:0] b);
		rec_bytes.insert(rec_bytes.size(), b);
	endfunction

	function automatic logic [BYTE_W-1:0] plain_byte();
		logic [BYTE_W-1:0] b;
		do
			b = BYTE_W'($urandom_range(0, 255));
		while (b == cur_delim || b == cur_quote);
		return b;
	endfunction

	function automatic logic [BYTE_W-1:0] noise_byte();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 3)
			return cur_delim;
		if (pick < 5)
			return cur_quote;
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	function automatic void add_field();
		int shape;
		int len;
		shape = $urandom_range(0, 3);
		len   = $urandom_range(0, 4);
		if (shape == 0)
			return;
		if (shape == 1) begin
			repeat (len + 1) add_byte(plain_byte());
			return;
		end
		add_byte(cur_quote);
		repeat (len) begin
			case ($urandom_range(0, 5))
				0: begin
					add_byte(cur_quote);
					add_byte(cur_quote);
				end
				1: add_byte(cur_delim);
				default: add_byte(plain_byte());
			endcase
		end
		add_byte(cur_quote);
	endfunction

	// mostly well-formed records, some cut short or with a stray quote, some noise
	function automatic void build_random_record();
		int kind;
		int n_fields;
		int cut;
		int f;
		rec_bytes.delete();
		kind = $urandom_range(0, 99);
		if (kind >= 85) begin
			repeat ($urandom_range(1, 8)) add_byte(noise_byte());
			return;
		end
		n_fields = ($urandom_range(0, 1) == 0) ? 3 : $urandom_range(1, 6);
		for (f = 0; f < n_fields; f++) begin
			if (f != 0)
				add_byte(cur_delim);
			add_field();
		end
		if ($urandom_range(0, 9) == 0)
			add_byte(cur_delim);
		if (rec_bytes.size() == 0)
			add_byte(plain_byte());
		if (kind >= 70) begin
			cut = $urandom_range(1, rec_bytes.size());
			while (rec_bytes.size() > cut)
				void'(rec_bytes.pop_back());
			if ($urandom_range(0, 1) == 1)
				rec_bytes.insert($urandom_range(0, rec_bytes.size()), cur_quote);
		end
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		in_valid       <= 1'b1;
		in_byte        <= b;
		last_of_record <= last;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_byte(b, last);
	endtask

	task automatic send_record();
		int i;
		for (i = 0; i < rec_bytes.size(); i++)
			send_byte(rec_bytes[i], i == rec_bytes.size() - 1);
	endtask

	// hold off until every beat is back and the queue has emptied
	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.write_reg(idx, val);
		if (idx == CFG_DELIM)
			cur_delim = val;
		else if (idx == CFG_QUOTE)
			cur_quote = val;
		@(posedge clk);
	endtask

	initial begin
		int phase;
		int sent;
		int failures;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (phase = 0; phase < N_SETTINGS; phase++) begin
			drain_results();
			write_reg(CFG_DELIM, delim_set[phase]);
			write_reg(CFG_QUOTE, quote_set[phase]);
			if (phase == 0) begin
				// trailing delimiter: count not stored
				rec_bytes = '{"a", DELIM_RESET, "b", DELIM_RESET};
				send_record();
				// quoted delimiter, doubled quote, empty field, 0xff; stores 3
				rec_bytes = '{QUOTE_RESET, "a", DELIM_RESET, QUOTE_RESET, QUOTE_RESET,
					QUOTE_RESET, DELIM_RESET, DELIM_RESET, 8'hff};
				send_record();
				rec_bytes = '{8'h00, 8'h0d, 8'h0a};
				send_record();
				// quote left open at record end
				rec_bytes = '{"x", DELIM_RESET, "y", DELIM_RESET, QUOTE_RESET, DELIM_RESET};
				send_record();
				rec_bytes = '{DELIM_RESET};
				send_record();
				rec_bytes = '{QUOTE_RESET};
				send_record();
				// saturate the field count
				rec_bytes.delete();
				repeat (257) add_byte(DELIM_RESET);
				add_byte("z");
				send_record();
			end
			sent = 0;
			while (sent < BYTES_PER_PHASE) begin
				build_random_record();
				send_record();
				sent += rec_bytes.size();
			end
		end
		drain_results();
		repeat (8) @(posedge clk);
		failures = sb.bad_beats + sb.pending();
		$display("run covered %0d bytes in %0d records under %0d delimiter/quote settings",
			sb.bytes_seen, sb.records_seen, N_SETTINGS);
		$display("records: %0d ok, %0d trailing delimiter, %0d count mismatch; %0d doubled quotes",
			sb.status_seen[ST_OK], sb.status_seen[ST_TRAILING], sb.status_seen[ST_MISMATCH],
			sb.doubled_quotes);
		if (failures == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d bad beats", failures);
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout");
		$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: files.f
+incdir+design
design/ctk_pkg.sv
design/ctk_fifo.sv
design/ctk_front.sv
design/ctk_back.sv
design/csv_field_tokenizer.sv
design/ctk_checker.sv
tb/tb_top.sv
